### rtl/gpfat_pkg.sv
// ----------------------------------------------------------------------------
// gpfat_pkg
// Shared types and constants for the game packet filter and announce table.
// ----------------------------------------------------------------------------
package gpfat_pkg;

  localparam int unsigned TABLE_ENTRIES = 7;
  localparam int unsigned CountW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned IdxW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam logic [7:0] PktLenOk   = 8'd32;
  localparam logic [7:0] ChProto    = 8'h47;
  localparam logic [7:0] ChText     = 8'h54;
  localparam logic [7:0] ChNick     = 8'h4E;
  localparam logic [7:0] ChAnnounce = 8'h41;

  localparam logic [1:0] OpPacket  = 2'd0;
  localparam logic [1:0] OpClear   = 2'd1;
  localparam logic [1:0] OpReserve = 2'd2;

  localparam logic [2:0] KindDrop     = 3'd0;
  localparam logic [2:0] KindText     = 3'd1;
  localparam logic [2:0] KindNick     = 3'd2;
  localparam logic [2:0] KindAnnounce = 3'd3;
  localparam logic [2:0] KindOther    = 3'd4;
  localparam logic [2:0] KindCleared  = 3'd5;
  localparam logic [2:0] KindReserved = 3'd6;

  localparam logic [1:0] TblNone  = 2'd0;
  localparam logic [1:0] TblAdded = 2'd1;
  localparam logic [1:0] TblDup   = 2'd2;
  localparam logic [1:0] TblFull  = 2'd3;

  // Classified job handed from the front to the back
  typedef struct packed {
    logic [2:0]  kind;
    logic        send_ack;
    logic [31:0] ack_seq;
    logic [15:0] game_id;
  } job_t;

endpackage

### rtl/game_packet_filter_announce_table_core.sv
// ----------------------------------------------------------------------------
// game_packet_filter_announce_table_core
// Packet filter, command classifier and game announce table for a radio game.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// input     in         push / full            op, pkt_len, proto_byte, cmd_byte,
//                                             dest_id, pkt_seq, game_id
// result    out        empty / pop            kind, send_ack, ack_seq, new_seq,
//                                             table_result, slot
// config    in         cfg_we_i               cfg_wdata_i (station id)
//
// An item passes a front register and a two-entry job queue, then the back
// unit executes one job at a time. When the back is free, a result passes the
// front register, the queue and the result register; an announce to a table
// not yet full first scans the stored entries, one registered memory read and
// one compare per entry. The back starts a job only when the result register
// is empty; the front and the queue keep accepting meanwhile. Reset empties
// the table and sets the sequence counter to 1; no clearing pass is needed.
// ----------------------------------------------------------------------------
module game_packet_filter_announce_table_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  op_i,
  input  logic [7:0]  pkt_len_i,
  input  logic [7:0]  proto_byte_i,
  input  logic [7:0]  cmd_byte_i,
  input  logic [31:0] dest_id_i,
  input  logic [31:0] pkt_seq_i,
  input  logic [15:0] game_id_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  kind_o,
  output logic        send_ack_o,
  output logic [31:0] ack_seq_o,
  output logic [31:0] new_seq_o,
  output logic [1:0]  table_result_o,
  output logic [2:0]  slot_o
);
  import gpfat_pkg::*;

  logic front_valid, q_ready, q_valid, q_pop;
  job_t front_job, q_job;

  gpfat_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .push         (push),
    .full         (full),
    .op_i         (op_i),
    .pkt_len_i    (pkt_len_i),
    .proto_byte_i (proto_byte_i),
    .cmd_byte_i   (cmd_byte_i),
    .dest_id_i    (dest_id_i),
    .pkt_seq_i    (pkt_seq_i),
    .game_id_i    (game_id_i),
    .job_valid_o  (front_valid),
    .job_o        (front_job),
    .job_ready_i  (q_ready)
  );

  gpfat_jobq u_jobq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (front_valid),
    .wr_job_i   (front_job),
    .wr_ready_o (q_ready),
    .rd_valid_o (q_valid),
    .rd_job_o   (q_job),
    .rd_pop_i   (q_pop)
  );

  gpfat_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (q_valid),
    .job_i          (q_job),
    .job_pop_o      (q_pop),
    .empty          (empty),
    .pop            (pop),
    .kind_o         (kind_o),
    .send_ack_o     (send_ack_o),
    .ack_seq_o      (ack_seq_o),
    .new_seq_o      (new_seq_o),
    .table_result_o (table_result_o),
    .slot_o         (slot_o)
  );

endmodule

### rtl/gpfat_front.sv
// ----------------------------------------------------------------------------
// gpfat_front
// Accepts items, checks the packet filter and decodes the command into a job.
// ----------------------------------------------------------------------------
module gpfat_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         op_i,
  input  logic [7:0]         pkt_len_i,
  input  logic [7:0]         proto_byte_i,
  input  logic [7:0]         cmd_byte_i,
  input  logic [31:0]        dest_id_i,
  input  logic [31:0]        pkt_seq_i,
  input  logic [15:0]        game_id_i,
  output logic               job_valid_o,
  output gpfat_pkg::job_t    job_o,
  input  logic               job_ready_i
);
  import gpfat_pkg::*;

  logic [31:0] station_id_q;
  logic        valid_q;
  job_t        job_q, job_d;
  logic        pkt_ok, accept;

  assign full   = valid_q && !job_ready_i;
  assign accept = push && !full;

  assign pkt_ok = (pkt_len_i == PktLenOk) && (proto_byte_i == ChProto) &&
                  ((dest_id_i == station_id_q) || (dest_id_i == 32'd0));

  always_comb begin
    job_d          = '0;
    job_d.game_id  = game_id_i;
    case (op_i)
      OpClear:   job_d.kind = KindCleared;
      OpReserve: job_d.kind = KindReserved;
      OpPacket: begin
        if (pkt_ok) begin
          case (cmd_byte_i)
            ChText: begin
              job_d.kind = KindText;
              if (dest_id_i != 32'd0) begin
                job_d.send_ack = 1'b1;
                job_d.ack_seq  = pkt_seq_i;
              end
            end
            ChNick:     job_d.kind = KindNick;
            ChAnnounce: job_d.kind = KindAnnounce;
            default:    job_d.kind = KindOther;
          endcase
        end
      end
      default: job_d.kind = KindDrop;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      station_id_q <= '0;
      valid_q      <= 1'b0;
      job_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        station_id_q <= cfg_wdata_i;
      end
      if (accept) begin
        valid_q <= 1'b1;
        job_q   <= job_d;
      end else if (job_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign job_valid_o = valid_q;
  assign job_o       = job_q;

endmodule

### rtl/gpfat_jobq.sv
// ----------------------------------------------------------------------------
// gpfat_jobq
// Two-entry queue of classified jobs between the front and the back.
// ----------------------------------------------------------------------------
module gpfat_jobq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_valid_i,
  input  gpfat_pkg::job_t    wr_job_i,
  output logic               wr_ready_o,
  output logic               rd_valid_o,
  output gpfat_pkg::job_t    rd_job_o,
  input  logic               rd_pop_i
);
  import gpfat_pkg::*;

  job_t       entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_wr, do_rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_job_o   = entry_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_pop_i && rd_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_rd) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({do_wr, do_rd})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      entry_q[wr_ptr_q] <= wr_job_i;
    end
  end

endmodule

### rtl/gpfat_back.sv
// ----------------------------------------------------------------------------
// gpfat_back
// Executes jobs: sequence counter, announce table scan, result register.
// ----------------------------------------------------------------------------
module gpfat_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  input  gpfat_pkg::job_t    job_i,
  output logic               job_pop_o,
  output logic               empty,
  input  logic               pop,
  output logic [2:0]         kind_o,
  output logic               send_ack_o,
  output logic [31:0]        ack_seq_o,
  output logic [31:0]        new_seq_o,
  output logic [1:0]         table_result_o,
  output logic [2:0]         slot_o
);
  import gpfat_pkg::*;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_CMP
  } state_e;

  state_e            state_q;
  logic [31:0]       seq_q;
  logic [CountW-1:0] count_q;
  logic [CountW-1:0] idx_q;
  logic [15:0]       gid_q;
  logic              out_valid_q;
  logic [2:0]        kind_q;
  logic              send_ack_q;
  logic [31:0]       ack_seq_q;
  logic [31:0]       new_seq_q;
  logic [1:0]        tbl_q;
  logic [2:0]        slot_q;

  logic [15:0]       mem [TABLE_ENTRIES];
  logic [15:0]       rd_q;
  logic              take, scan_end, mem_we;

  assign take      = (state_q == B_IDLE) && job_valid_i && !out_valid_q;
  assign job_pop_o = take;
  assign scan_end  = (state_q == B_SCAN) && (idx_q == count_q);
  assign mem_we    = scan_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      seq_q       <= 32'd1;
      count_q     <= '0;
      idx_q       <= '0;
      gid_q       <= '0;
      out_valid_q <= 1'b0;
      kind_q      <= KindDrop;
      send_ack_q  <= 1'b0;
      ack_seq_q   <= '0;
      new_seq_q   <= '0;
      tbl_q       <= TblNone;
      slot_q      <= '0;
    end else begin
      if (pop && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (take) begin
            kind_q     <= job_i.kind;
            send_ack_q <= job_i.send_ack;
            ack_seq_q  <= job_i.ack_seq;
            new_seq_q  <= '0;
            tbl_q      <= TblNone;
            slot_q     <= '0;
            gid_q      <= job_i.game_id;
            idx_q      <= '0;
            case (job_i.kind)
              KindNick, KindReserved: begin
                seq_q       <= seq_q + 32'd1;
                new_seq_q   <= seq_q + 32'd1;
                out_valid_q <= 1'b1;
              end
              KindCleared: begin
                count_q     <= '0;
                out_valid_q <= 1'b1;
              end
              KindAnnounce: begin
                if (count_q == CountW'(TABLE_ENTRIES)) begin
                  tbl_q       <= TblFull;
                  out_valid_q <= 1'b1;
                end else begin
                  state_q <= B_SCAN;
                end
              end
              default: out_valid_q <= 1'b1;
            endcase
          end
        end
        B_SCAN: begin
          if (scan_end) begin
            // no match among stored entries: append
            tbl_q       <= TblAdded;
            slot_q      <= 3'(count_q);
            count_q     <= count_q + CountW'(1);
            out_valid_q <= 1'b1;
            state_q     <= B_IDLE;
          end else begin
            state_q <= B_CMP;
          end
        end
        B_CMP: begin
          if (rd_q == gid_q) begin
            tbl_q       <= TblDup;
            out_valid_q <= 1'b1;
            state_q     <= B_IDLE;
          end else begin
            idx_q   <= idx_q + CountW'(1);
            state_q <= B_SCAN;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[count_q[IdxW-1:0]] <= gid_q;
    end
    rd_q <= mem[idx_q[IdxW-1:0]];
  end

  assign empty          = !out_valid_q;
  assign kind_o         = kind_q;
  assign send_ack_o     = send_ack_q;
  assign ack_seq_o      = ack_seq_q;
  assign new_seq_o      = new_seq_q;
  assign table_result_o = tbl_q;
  assign slot_o         = slot_q;

endmodule
